// ===== rtl/core/cfir_pkg.sv =====
// shared types and constants of the complex fir filter
package cfir_pkg;

    localparam int REQ_W       = 2;
    localparam int NUM_TAPS_W  = 7;
    localparam int TAP_INDEX_W = 6;

    localparam logic [REQ_W-1:0] REQ_FILTER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TAP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_RUN,
        S_DRAIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic init_step;
        logic start;
        logic tap_write;
        logic clear;
        logic issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic             in_valid;
        logic [REQ_W-1:0] req_type;
        logic             init_done;
        logic             n_zero;
        logic             last_issue;
        logic             pipe_busy;
        logic             out_free;
    } status_t;

endpackage

// ===== rtl/core/cfir_req_if.sv =====
// request channel: sample, tap load or clear
interface cfir_req_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [cfir_pkg::REQ_W-1:0]           req_type;
    logic signed [SAMPLE_WIDTH-1:0]       sample_re;
    logic signed [SAMPLE_WIDTH-1:0]       sample_im;
    logic [cfir_pkg::TAP_INDEX_W-1:0]     tap_index;
    logic signed [SAMPLE_WIDTH-1:0]       tap_re;
    logic signed [SAMPLE_WIDTH-1:0]       tap_im;

    modport source (
        output valid, req_type, sample_re, sample_im, tap_index, tap_re, tap_im,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample_re, sample_im, tap_index, tap_re, tap_im,
        output ready
    );
endinterface

// ===== rtl/core/cfir_res_if.sv =====
// result channel: filtered complex sample
interface cfir_res_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;

    modport source (
        output valid, out_re, out_im,
        input  ready
    );
    modport sink (
        input  valid, out_re, out_im,
        output ready
    );
endinterface

// ===== rtl/core/cfir_ram.sv =====
// generic single write port ram with registered read
module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/cfir_ctrl.sv =====
// controller state machine of the complex fir filter
module cfir_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  cfir_pkg::status_t status,
    output cfir_pkg::cmd_t    cmd
);
    cfir_pkg::state_t state_reg;
    cfir_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfir_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfir_pkg::S_INIT:
            begin
                if (status.init_done)
                begin
                    state_next = cfir_pkg::S_IDLE;
                end
            end
            cfir_pkg::S_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = cfir_pkg::S_DISPATCH;
                end
            end
            cfir_pkg::S_DISPATCH:
            begin
                if (status.req_type == cfir_pkg::REQ_FILTER)
                begin
                    state_next = status.n_zero ? cfir_pkg::S_OUT : cfir_pkg::S_RUN;
                end
                else
                begin
                    state_next = cfir_pkg::S_IDLE;
                end
            end
            cfir_pkg::S_RUN:
            begin
                if (status.last_issue)
                begin
                    state_next = cfir_pkg::S_DRAIN;
                end
            end
            cfir_pkg::S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = cfir_pkg::S_OUT;
                end
            end
            cfir_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = cfir_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfir_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            cfir_pkg::S_INIT:
            begin
                cmd.init_step = 1'b1;
            end
            cfir_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            cfir_pkg::S_DISPATCH:
            begin
                unique case (status.req_type)
                    cfir_pkg::REQ_FILTER: cmd.start     = !status.n_zero;
                    cfir_pkg::REQ_TAP:    cmd.tap_write = 1'b1;
                    cfir_pkg::REQ_CLEAR:  cmd.clear     = 1'b1;
                    default:              cmd           = '0;
                endcase
            end
            cfir_pkg::S_RUN:
            begin
                cmd.issue = 1'b1;
            end
            cfir_pkg::S_DRAIN:
            begin
                cmd = '0;
            end
            cfir_pkg::S_OUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

// ===== rtl/core/cfir_dp.sv =====
// datapath: tap and delay memories, complex multiply-accumulate, output register
module cfir_dp #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cfir_req_if.sink                      req,
    cfir_res_if.source                    res,
    input  logic                          cfg_wr_en,
    input  logic [cfir_pkg::NUM_TAPS_W-1:0] cfg_wr_data,
    input  cfir_pkg::cmd_t                cmd,
    output cfir_pkg::status_t             status
);
    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(MAX_TAPS);
    localparam int CW   = $clog2(MAX_TAPS + 1);
    localparam int NW   = (CW > cfir_pkg::NUM_TAPS_W) ? CW : cfir_pkg::NUM_TAPS_W;
    localparam int IW   = (CW > cfir_pkg::TAP_INDEX_W) ? CW : cfir_pkg::TAP_INDEX_W;
    localparam int PW   = 2 * SW;
    localparam int ACCW = 2 * SW + 8;
    localparam int FRAC = SW - 1;
    localparam int VW   = ACCW + 1;
    localparam int QW   = VW - FRAC;
    localparam logic signed [QW-1:0] Q_HI  = QW'((2 ** (SW - 1)) - 1);
    localparam logic signed [QW-1:0] Q_LO  = -Q_HI - QW'(1);
    localparam logic signed [VW-1:0] ROUND = VW'(2 ** (FRAC - 1));

    // captured request
    logic [cfir_pkg::REQ_W-1:0]       req_type_reg;
    logic signed [SW-1:0]             sample_re_reg;
    logic signed [SW-1:0]             sample_im_reg;
    logic [cfir_pkg::TAP_INDEX_W-1:0] tap_index_reg;
    logic signed [SW-1:0]             tap_re_reg;
    logic signed [SW-1:0]             tap_im_reg;

    // control state
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [AW-1:0] init_cnt_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [CW-1:0] k_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic          dvalid_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    // arithmetic
    logic signed [PW-1:0]   p_rr_reg;
    logic signed [PW-1:0]   p_ii_reg;
    logic signed [PW-1:0]   p_ri_reg;
    logic signed [PW-1:0]   p_ir_reg;
    logic signed [ACCW-1:0] acc_re_reg;
    logic signed [ACCW-1:0] acc_im_reg;
    logic signed [SW-1:0]   out_re_reg;
    logic signed [SW-1:0]   out_im_reg;
    logic signed [SW-1:0]   fin_re;
    logic signed [SW-1:0]   fin_im;

    // memories
    logic [PW-1:0] tap_rdata;
    logic [PW-1:0] dly_rdata;
    logic          tap_we;
    logic [AW-1:0] tap_waddr;
    logic [PW-1:0] tap_wdata;
    logic [IW-1:0] ti_ext;
    logic          ti_ok;
    logic signed [SW-1:0] d_re;
    logic signed [SW-1:0] d_im;
    logic signed [SW-1:0] t_re;
    logic signed [SW-1:0] t_im;
    logic [CW-1:0] n_minus1;

    assign n_minus1 = n_reg - CW'(1);
    assign ti_ext   = IW'(tap_index_reg);
    assign ti_ok    = ti_ext < IW'(MAX_TAPS);

    // request capture
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_type_reg  <= req.req_type;
            sample_re_reg <= req.sample_re;
            sample_im_reg <= req.sample_im;
            tap_index_reg <= req.tap_index;
            tap_re_reg    <= req.tap_re;
            tap_im_reg    <= req.tap_im;
        end
    end

    assign req.ready = cmd.in_ready;

    // tap count, write position and fill count of the delay line
    always_comb
    begin
        n_next    = n_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (cfg_wr_en)
        begin
            n_next    = (NW'(cfg_wr_data) > NW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(cfg_wr_data);
            wp_next   = '0;
            fill_next = '0;
        end
        else if (cmd.clear)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        else if (cmd.start)
        begin
            wp_next   = (CW'(wp_reg) == n_minus1) ? '0 : wp_reg + AW'(1);
            fill_next = (fill_reg < n_reg) ? fill_reg + CW'(1) : fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            init_cnt_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
        end
    end

    // read sequencing over the taps, newest sample first
    assign pos_next = (pos_reg == '0) ? n_minus1[AW-1:0] : pos_reg - AW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pos_reg <= wp_reg;
            k_reg   <= '0;
        end
        else if (cmd.issue)
        begin
            pos_reg <= pos_next;
            k_reg   <= k_reg + CW'(1);
        end
        dvalid_reg <= CW'(pos_reg) < fill_reg;
    end

    // tap memory, swept to zero after reset
    assign tap_we    = cmd.init_step || (cmd.tap_write && ti_ok);
    assign tap_waddr = cmd.init_step ? init_cnt_reg : ti_ext[AW-1:0];
    assign tap_wdata = cmd.init_step ? '0 : {tap_im_reg, tap_re_reg};

    cfir_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (tap_rdata)
    );

    cfir_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_TAPS)
    ) u_dly_ram (
        .clk   (clk),
        .we    (cmd.start),
        .waddr (wp_reg),
        .wdata ({sample_im_reg, sample_re_reg}),
        .raddr (pos_reg),
        .rdata (dly_rdata)
    );

    // entries not written since the last clear read as zero
    assign d_re = dvalid_reg ? signed'(dly_rdata[SW-1:0])  : '0;
    assign d_im = dvalid_reg ? signed'(dly_rdata[PW-1:SW]) : '0;
    assign t_re = signed'(tap_rdata[SW-1:0]);
    assign t_im = signed'(tap_rdata[PW-1:SW]);

    always_ff @(posedge clk)
    begin
        p_rr_reg <= d_re * t_re;
        p_ii_reg <= d_im * t_im;
        p_ri_reg <= d_re * t_im;
        p_ir_reg <= d_im * t_re;
        if (cmd.start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACCW'(p_rr_reg) - ACCW'(p_ii_reg);
            acc_im_reg <= acc_im_reg + ACCW'(p_ri_reg) + ACCW'(p_ir_reg);
        end
    end

    // round half up, shift and saturate
    always_comb
    begin
        logic signed [VW-1:0] v_re;
        logic signed [VW-1:0] v_im;
        logic signed [QW-1:0] q_re;
        logic signed [QW-1:0] q_im;
        v_re = VW'(acc_re_reg) + ROUND;
        v_im = VW'(acc_im_reg) + ROUND;
        q_re = QW'(v_re >>> FRAC);
        q_im = QW'(v_im >>> FRAC);
        if (q_re > Q_HI)
        begin
            fin_re = Q_HI[SW-1:0];
        end
        else if (q_re < Q_LO)
        begin
            fin_re = Q_LO[SW-1:0];
        end
        else
        begin
            fin_re = q_re[SW-1:0];
        end
        if (q_im > Q_HI)
        begin
            fin_im = Q_HI[SW-1:0];
        end
        else if (q_im < Q_LO)
        begin
            fin_im = Q_LO[SW-1:0];
        end
        else
        begin
            fin_im = q_im[SW-1:0];
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_re_reg <= (n_reg == '0) ? sample_re_reg : fin_re;
            out_im_reg <= (n_reg == '0) ? sample_im_reg : fin_im;
        end
    end

    assign res.valid  = out_valid_reg;
    assign res.out_re = out_re_reg;
    assign res.out_im = out_im_reg;

    always_comb
    begin
        status            = '0;
        status.in_valid   = req.valid;
        status.req_type   = req_type_reg;
        status.init_done  = init_cnt_reg == AW'(MAX_TAPS - 1);
        status.n_zero     = n_reg == '0;
        status.last_issue = k_reg == n_minus1;
        status.pipe_busy  = v1_reg || v2_reg;
        status.out_free   = !out_valid_reg || res.ready;
    end
endmodule

// ===== rtl/core/complex_fir_filter_unit.sv =====
// top level of the complex fir filter over i/q samples
//
// req carries one request per transfer: filter a sample, load one complex
// tap at tap_index, or clear the delay line. res carries one filtered sample
// for every filter request. cfg_wr_en/cfg_wr_data write num_taps, which also
// clears the delay line; write it only while the block is idle.
// A filter request runs one complex multiply-accumulate per tap in use,
// paced by the single read port of the tap and delay memories, then waits
// for the multiply-accumulate pipeline to drain and loads the result
// register; the next request is taken after that. Tap loads and clears
// are done in the dispatch state before the next request is taken.
// With num_taps at zero a sample goes from dispatch straight to the result
// register unchanged, and the next request is taken after that.
// After reset the tap memory is swept to zero over all MAX_TAPS entries,
// during which req.ready stays low; num_taps resets to zero.
// The result sits in an output register; while res.ready is low the next
// request is still taken and computed, and it then waits for the register
// to free up before req.ready rises again.
module complex_fir_filter_unit #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cfir_req_if.sink                        req,
    cfir_res_if.source                      res,
    input  logic                            cfg_wr_en,
    input  logic [cfir_pkg::NUM_TAPS_W-1:0] cfg_wr_data
);
    cfir_pkg::cmd_t    cmd;
    cfir_pkg::status_t status;

    cfir_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    cfir_dp #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );
endmodule

// ===== dv/complex_fir_filter_unit_test.sv =====
// self-checking test of the complex fir filter unit with a tracking filter copy
module complex_fir_filter_unit_test;

    localparam int                         MAX_TAPS     = 64;
    localparam int                         SW           = 16;
    localparam int                         TIW          = cfir_pkg::TAP_INDEX_W;
    localparam logic [cfir_pkg::REQ_W-1:0] REQ_UNUSED   = 2'd3;
    localparam int                         DRAIN_CYCLES = 80;
    localparam int                         QUIET_LIMIT  = 2000;
    localparam int                         PHASE_ITEMS  = 80;

    class fir_response_tracker;
        logic signed [SW-1:0] coef_re [MAX_TAPS];
        logic signed [SW-1:0] coef_im [MAX_TAPS];
        logic signed [SW-1:0] line_re [MAX_TAPS];
        logic signed [SW-1:0] line_im [MAX_TAPS];
        int unsigned          head;
        int unsigned          taps_cfg;
        logic signed [SW-1:0] filtered_re_q [$];
        logic signed [SW-1:0] filtered_im_q [$];
        int unsigned          errors;
        int unsigned          checked;
        int unsigned          filters;
        int unsigned          tap_loads;
        int unsigned          clears;
        int unsigned          settings;

        function new();
            foreach (coef_re[k])
            begin
                coef_re[k] = '0;
                coef_im[k] = '0;
            end
            clear_line();
            taps_cfg  = 0;
            errors    = 0;
            checked   = 0;
            filters   = 0;
            tap_loads = 0;
            clears    = 0;
            settings  = 0;
        endfunction

        function void clear_line();
            foreach (line_re[k])
            begin
                line_re[k] = '0;
                line_im[k] = '0;
            end
            head = 0;
        endfunction

        function void set_taps(input logic [cfir_pkg::NUM_TAPS_W-1:0] value);
            taps_cfg = value;
            clear_line();
            settings++;
        endfunction

        // wrap to 40 bits, round half up, shift by 15, saturate
        function logic signed [SW-1:0] round_sat(input longint acc);
            longint v;
            v = longint'(signed'(acc[39:0]));
            v = (v + 64'sd16384) >>> 15;
            if (v > 64'sd32767)
                v = 64'sd32767;
            if (v < -64'sd32768)
                v = -64'sd32768;
            return v[SW-1:0];
        endfunction

        task accept_request(input logic [cfir_pkg::REQ_W-1:0] rt,
                            input logic signed [SW-1:0] sre, input logic signed [SW-1:0] sim,
                            input logic [TIW-1:0] tidx,
                            input logic signed [SW-1:0] tre, input logic signed [SW-1:0] tim);
            longint      acc_re;
            longint      acc_im;
            int unsigned n;
            int unsigned p;
            acc_re = 0;
            acc_im = 0;
            if (rt == cfir_pkg::REQ_TAP)
            begin
                tap_loads++;
                if (tidx < MAX_TAPS)
                begin
                    coef_re[tidx] = tre;
                    coef_im[tidx] = tim;
                end
            end
            else if (rt == cfir_pkg::REQ_CLEAR)
            begin
                clears++;
                clear_line();
            end
            else if (rt == cfir_pkg::REQ_FILTER)
            begin
                filters++;
                n = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
                if (n == 0)
                begin
                    filtered_re_q.push_back(sre);
                    filtered_im_q.push_back(sim);
                end
                else
                begin
                    if (head >= n)
                        head = 0;
                    line_re[head] = sre;
                    line_im[head] = sim;
                    p = head;
                    for (int k = 0; k < n; k++)
                    begin
                        acc_re += longint'(line_re[p]) * longint'(coef_re[k])
                                - longint'(line_im[p]) * longint'(coef_im[k]);
                        acc_im += longint'(line_re[p]) * longint'(coef_im[k])
                                + longint'(line_im[p]) * longint'(coef_re[k]);
                        p = (p == 0) ? n - 1 : p - 1;
                    end
                    head = (head + 1) % n;
                    filtered_re_q.push_back(round_sat(acc_re));
                    filtered_im_q.push_back(round_sat(acc_im));
                end
            end
        endtask

        task report(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_output(input logic signed [SW-1:0] got_re, input logic signed [SW-1:0] got_im);
            logic signed [SW-1:0] want_re;
            logic signed [SW-1:0] want_im;
            if (filtered_re_q.size() == 0)
            begin
                report($sformatf("result %0d/%0d with nothing pending", got_re, got_im));
            end
            else
            begin
                want_re = filtered_re_q.pop_front();
                want_im = filtered_im_q.pop_front();
                checked++;
                if (got_re !== want_re)
                    report($sformatf("out_re %0d, want %0d", got_re, want_re));
                if (got_im !== want_im)
                    report($sformatf("out_im %0d, want %0d", got_im, want_im));
            end
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [cfir_pkg::NUM_TAPS_W-1:0] cfg_wr_data;
    bit                              burst;
    int                              quiet;
    int                              res_stall;
    fir_response_tracker             board;

    cfir_req_if #(.SAMPLE_WIDTH(SW)) req_ch ();
    cfir_res_if #(.SAMPLE_WIDTH(SW)) res_ch ();

    complex_fir_filter_unit #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_wait();
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic signed [SW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic send_req(input logic [cfir_pkg::REQ_W-1:0] rt,
                            input logic signed [SW-1:0] sre, input logic signed [SW-1:0] sim,
                            input logic [TIW-1:0] tidx,
                            input logic signed [SW-1:0] tre, input logic signed [SW-1:0] tim);
        int gap;
        gap = draw_wait();
        if ($urandom_range(0, 24) == 0)
            burst = !burst;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.sample_re <= sre;
        req_ch.sample_im <= sim;
        req_ch.tap_index <= tidx;
        req_ch.tap_re    <= tre;
        req_ch.tap_im    <= tim;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.accept_request(rt, sre, sim, tidx, tre, tim);
    endtask

    task automatic send_sample(input logic signed [SW-1:0] sre, input logic signed [SW-1:0] sim);
        send_req(cfir_pkg::REQ_FILTER, sre, sim, TIW'($urandom), SW'($urandom), SW'($urandom));
    endtask

    task automatic send_tap(input logic [TIW-1:0] tidx,
                            input logic signed [SW-1:0] tre, input logic signed [SW-1:0] tim);
        send_req(cfir_pkg::REQ_TAP, SW'($urandom), SW'($urandom), tidx, tre, tim);
    endtask

    task automatic send_plain(input logic [cfir_pkg::REQ_W-1:0] rt);
        send_req(rt, SW'($urandom), SW'($urandom), TIW'($urandom), SW'($urandom),
                 SW'($urandom));
    endtask

    // drop valid, wait for every pending result, then let the pipeline empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (board.filtered_re_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_taps(input logic [cfir_pkg::NUM_TAPS_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_taps(value);
    endtask

    task automatic run_phase(input logic [cfir_pkg::NUM_TAPS_W-1:0] value);
        int count;
        int n;
        int r;
        count = 0;
        write_num_taps(value);
        n = (value > MAX_TAPS) ? MAX_TAPS : value;
        for (int k = 0; k < n; k++)
        begin
            send_tap(TIW'(k), pick_value(), pick_value());
            count++;
        end
        while (count < PHASE_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
            begin
                send_sample(pick_value(), pick_value());
                count++;
            end
            else if (r < 88)
            begin
                send_tap(TIW'($urandom_range(0, MAX_TAPS - 1)), pick_value(), pick_value());
                count++;
            end
            else if (r < 94)
            begin
                send_plain(cfir_pkg::REQ_CLEAR);
                count++;
            end
            else
            begin
                send_plain(REQ_UNUSED);
            end
        end
    endtask

    // result side with random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                board.check_output(res_ch.out_re, res_ch.out_im);
                res_stall = draw_wait();
            end
            if (res_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                res_stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        board            = new();
        burst            = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= cfir_pkg::REQ_FILTER;
        req_ch.sample_re <= '0;
        req_ch.sample_im <= '0;
        req_ch.tap_index <= '0;
        req_ch.tap_re    <= '0;
        req_ch.tap_im    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // pass-through with taps at zero, loads and clears do not disturb it
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh0000, 16'shFFFF);
        send_tap(6'd63, 16'sh7FFF, 16'sh8000);
        send_tap(6'd0, 16'sh8000, 16'sh8000);
        send_plain(cfir_pkg::REQ_CLEAR);
        send_plain(REQ_UNUSED);
        send_sample(16'sh0001, 16'sh0000);

        // short filter with extreme taps, saturation and rounding
        write_num_taps(7'd4);
        send_tap(6'd1, 16'sh7FFF, 16'sh7FFF);
        send_tap(6'd2, 16'sh8000, 16'sh7FFF);
        send_tap(6'd3, 16'sh0001, 16'shFFFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'shFFFF);
        send_plain(cfir_pkg::REQ_CLEAR);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_tap(6'd2, 16'sh4000, 16'shC000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_plain(REQ_UNUSED);
        send_sample(16'sh0003, 16'shFFFD);

        run_phase(7'd1);
        run_phase(7'd64);
        run_phase(7'd0);
        run_phase(7'd3);
        run_phase(7'd127);
        run_phase(7'd2);
        run_phase(7'd65);
        run_phase(7'd17);
        run_phase(7'd0);
        run_phase(7'd40);
        run_phase(7'd5);

        settle();
        $display("covered %0d filter requests, %0d tap loads, %0d clears over %0d tap counts",
                 board.filters, board.tap_loads, board.clears, board.settings);
        $display("checked %0d results, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/cfir_pkg.sv
rtl/core/cfir_req_if.sv
rtl/core/cfir_res_if.sv
rtl/core/cfir_ram.sv
rtl/core/cfir_ctrl.sv
rtl/core/cfir_dp.sv
rtl/core/complex_fir_filter_unit.sv
dv/complex_fir_filter_unit_test.sv
